@@ rtl/core/wfgs_pkg.sv @@
// Package with types and constants of the wire-format group skipper.
`default_nettype none
package wfgs_pkg;
  localparam int MaxNestingDefault = 100;
  localparam int FieldW = 29;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TAG     = 3'd1,
    PH_VARINT  = 3'd2,
    PH_SIZE    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        data_byte;
    logic [FieldW-1:0] start_field;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] bytes_consumed;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/wfgs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module wfgs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [Width-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [Width-1:0] rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ rtl/core/wire_format_group_skipper_core.sv @@
// Top level of the wire-format group skipper.
// A result appears on the output register in the cycle after the transfer of the
// byte or end item that completes or breaks the skip.
// Throughput: one item per cycle while no held result is stalled; the group stack
// top sits in a register; the entry below it is read ahead, with a push forwarded.
// Reset clears all control state; the stack memory is not cleared.
`default_nettype none
module wire_format_group_skipper_core
  import wfgs_pkg::*;
#(
  parameter int MAX_NESTING = MaxNestingDefault,
  localparam int CW = $clog2(MAX_NESTING + 1),
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  // The memory holds entries below the top; the top lives in top_r.
  // Entry k of memory = stack element k (0-based) for k < count-1.
  phase_t            phase_r, phase_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [3:0]        vidx_r, vidx_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       bcnt_r, bcnt_nxt;
  logic [FieldW-1:0] top_r, top_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              emit;
  out_item_t         emit_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [FieldW-1:0] rd_data;
  logic              acc;
  // A push writes the entry that becomes the one below the top, so the
  // written value is forwarded from a register while the read catches up.
  logic              fwd_valid_r;
  logic [FieldW-1:0] fwd_data_r;
  logic [FieldW-1:0] below;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign below     = fwd_valid_r ? fwd_data_r : rd_data;

  wfgs_ram #(.Width(FieldW), .Depth(MAX_NESTING)) u_stack (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(top_r),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Decode of one item.
  always_comb begin
    logic [6:0]  low;
    logic        more;
    logic [31:0] tag;
    logic [28:0] field;
    logic [2:0]  wt;
    logic        do_fail, do_ok, tag_done;
    logic [CW-1:0] cm1;
    low = in_data.data_byte[6:0];
    more = in_data.data_byte[7];
    phase_nxt = phase_r; count_nxt = count_r; vidx_nxt = vidx_r;
    acc_nxt = acc_r; rem_nxt = rem_r; bcnt_nxt = bcnt_r; top_nxt = top_r;
    wr_en = 1'b0; wr_addr = '0;
    do_fail = 1'b0; do_ok = 1'b0; tag_done = 1'b0;
    tag = acc_r | ({25'd0, low} << (vidx_r * 7));
    field = tag[31:3]; wt = tag[2:0];
    cm1 = count_r - CW'(1);
    if (acc) begin
      if (opcode_t'(in_data.opcode) == OP_START) begin
        top_nxt = in_data.start_field; count_nxt = CW'(1);
        bcnt_nxt = '0; rem_nxt = '0; phase_nxt = PH_TAG;
        vidx_nxt = '0; acc_nxt = '0;
      end else if (phase_r != PH_IDLE) begin
        if (opcode_t'(in_data.opcode) == OP_END) begin
          do_fail = 1'b1;
        end else if (opcode_t'(in_data.opcode) == OP_BYTE) begin
          if (bcnt_r != 32'hFFFF_FFFF) bcnt_nxt = bcnt_r + 32'd1;
          unique case (phase_r)
            PH_TAG: begin
              acc_nxt = tag;
              if (!more) tag_done = 1'b1;
              else if (vidx_r >= 4'd4) do_fail = 1'b1;
              else vidx_nxt = vidx_r + 4'd1;
            end
            PH_VARINT: begin
              if (!more) begin
                phase_nxt = PH_TAG; vidx_nxt = '0; acc_nxt = '0;
              end else if (vidx_r >= 4'd9) do_fail = 1'b1;
              else vidx_nxt = vidx_r + 4'd1;
            end
            PH_SIZE: begin
              if (vidx_r >= 4'd4 && (low > 7'd15 || more)) do_fail = 1'b1;
              else begin
                acc_nxt = tag;
                if (more) vidx_nxt = vidx_r + 4'd1;
                else if (tag == 32'd0) begin
                  phase_nxt = PH_TAG; vidx_nxt = '0; acc_nxt = '0;
                end else begin
                  rem_nxt = tag; phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              rem_nxt = rem_r - 32'd1;
              if (rem_r == 32'd1) begin
                phase_nxt = PH_TAG; vidx_nxt = '0; acc_nxt = '0;
              end
            end
            default: ;
          endcase
          if (tag_done) begin
            if (field == 29'd0) do_fail = 1'b1;
            else begin
              case (wt)
                WT_VARINT: begin phase_nxt = PH_VARINT; vidx_nxt = '0; end
                WT_FIX64: begin phase_nxt = PH_PAYLOAD; rem_nxt = 32'd8; end
                WT_FIX32: begin phase_nxt = PH_PAYLOAD; rem_nxt = 32'd4; end
                WT_LEN: begin
                  phase_nxt = PH_SIZE; vidx_nxt = '0; acc_nxt = '0;
                end
                WT_SGROUP: begin
                  if (count_r >= CW'(MAX_NESTING)) do_fail = 1'b1;
                  else begin
                    // Old top spills to memory at index count-1.
                    if (count_r != '0) begin
                      wr_en = 1'b1; wr_addr = AW'(cm1);
                    end
                    top_nxt = field; count_nxt = count_r + CW'(1);
                    phase_nxt = PH_TAG; vidx_nxt = '0; acc_nxt = '0;
                  end
                end
                WT_EGROUP: begin
                  if (count_r == '0 || top_r != field) do_fail = 1'b1;
                  else if (count_r == CW'(1)) do_ok = 1'b1;
                  else begin
                    top_nxt = below; count_nxt = cm1;
                    phase_nxt = PH_TAG; vidx_nxt = '0; acc_nxt = '0;
                  end
                end
                default: do_fail = 1'b1;
              endcase
            end
          end
        end
      end
    end
    emit = do_fail || do_ok;
    emit_data.status = do_fail;
    emit_data.bytes_consumed = do_fail ? 32'd0 : bcnt_nxt;
    if (emit) begin
      phase_nxt = PH_IDLE; count_nxt = '0; vidx_nxt = '0;
      acc_nxt = '0; rem_nxt = '0;
    end
    // Read the entry that will sit just below the next top.
    rd_addr = (count_nxt >= CW'(2)) ? AW'(count_nxt - CW'(2)) : '0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; count_r <= '0; vidx_r <= '0; acc_r <= '0;
      rem_r <= '0; bcnt_r <= '0; out_valid_r <= 1'b0; fwd_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; count_r <= count_nxt; vidx_r <= vidx_nxt;
      acc_r <= acc_nxt; rem_r <= rem_nxt; bcnt_r <= bcnt_nxt;
      fwd_valid_r <= wr_en;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    fwd_data_r <= top_r;
    if (emit) out_data_r <= emit_data;
  end

  // Assertions.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_NESTING)) else $error("stack count overflow");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> count_r == '0) else $error("idle with stack");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("result lost under stall");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |-> out_data_r.bytes_consumed == 32'd0)
    else $error("failure with byte count");
endmodule
`default_nettype wire

@@ test/tb_skip_checker.sv @@
// Checker for the group skipper: predicts results from input transfers and compares outputs.
`timescale 1ns / 100ps
module tb_skip_checker
  import wfgs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             fail_count,
  output int             pending_results,
  output int             ok_results,
  output int             err_results
);
  // Shadow state of the skipper.
  logic [28:0] nest_stack [0:MaxNestingDefault-1];
  int unsigned nest_depth;
  phase_t      cur_phase;
  int unsigned vidx;
  logic [31:0] accum;
  logic [31:0] left_bytes;
  logic [31:0] consumed;
  out_item_t   expected_q [$];

  // Record one result and return the shadow state to idle.
  task automatic finish_skip(input logic st, input logic [31:0] cnt);
    out_item_t r;
    r.status = st;
    r.bytes_consumed = cnt;
    expected_q.insert(expected_q.size(), r);
    cur_phase = PH_IDLE;
    nest_depth = 0;
    vidx = 0;
    accum = '0;
    left_bytes = '0;
  endtask

  task automatic open_tag();
    cur_phase = PH_TAG;
    vidx = 0;
    accum = '0;
  endtask

  // Dispatch on the wire type once a tag is complete.
  task automatic tag_complete();
    logic [31:0] fld;
    logic [2:0]  wt;
    fld = accum >> 3;
    wt = accum[2:0];
    if (fld == 0) begin
      finish_skip(1'b1, '0);
      return;
    end
    case (wt)
      WT_VARINT: begin
        cur_phase = PH_VARINT;
        vidx = 0;
      end
      WT_FIX64: begin
        cur_phase = PH_PAYLOAD;
        left_bytes = 8;
      end
      WT_LEN: begin
        cur_phase = PH_SIZE;
        vidx = 0;
        accum = '0;
      end
      WT_SGROUP: begin
        if (nest_depth >= MaxNestingDefault) finish_skip(1'b1, '0);
        else begin
          nest_stack[nest_depth] = fld[28:0];
          nest_depth++;
          open_tag();
        end
      end
      WT_EGROUP: begin
        if (nest_depth == 0) finish_skip(1'b1, '0);
        else begin
          nest_depth--;
          if ({3'b0, nest_stack[nest_depth]} != fld) finish_skip(1'b1, '0);
          else if (nest_depth == 0) finish_skip(1'b0, consumed);
          else open_tag();
        end
      end
      WT_FIX32: begin
        cur_phase = PH_PAYLOAD;
        left_bytes = 4;
      end
      default: finish_skip(1'b1, '0);
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [31:0] low;
    logic        more;
    low = {25'b0, b[6:0]};
    more = b[7];
    if (consumed != 32'hFFFF_FFFF) consumed++;
    case (cur_phase)
      PH_TAG: begin
        accum |= low << (vidx * 7);
        if (!more) tag_complete();
        else if (vidx >= 4) finish_skip(1'b1, '0);
        else vidx++;
      end
      PH_VARINT: begin
        if (!more) open_tag();
        else if (vidx >= 9) finish_skip(1'b1, '0);
        else vidx++;
      end
      PH_SIZE: begin
        if (vidx >= 4 && (low > 15 || more)) finish_skip(1'b1, '0);
        else begin
          accum |= low << (vidx * 7);
          if (more) vidx++;
          else begin
            left_bytes = accum;
            if (left_bytes == 0) open_tag();
            else cur_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        left_bytes--;
        if (left_bytes == 0) open_tag();
      end
      default: ;
    endcase
  endtask

  // Predict on input transfers and compare on output transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      nest_depth = 0;
      cur_phase = PH_IDLE;
      vidx = 0;
      accum = '0;
      left_bytes = '0;
      consumed = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d bytes_consumed %0d",
                 out_data.status, out_data.bytes_consumed);
          fail_count++;
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (e.status != out_data.status) begin
            $error("status: expected %0d actual %0d", e.status, out_data.status);
            fail_count++;
          end
          if (e.bytes_consumed != out_data.bytes_consumed) begin
            $error("bytes_consumed: expected %0d actual %0d",
                   e.bytes_consumed, out_data.bytes_consumed);
            fail_count++;
          end
          if (e.status) err_results++;
          else ok_results++;
        end
      end
      if (in_valid && !in_stall) begin
        case (opcode_t'(in_data.opcode))
          OP_START: begin
            nest_stack[0] = in_data.start_field;
            nest_depth = 1;
            consumed = '0;
            left_bytes = '0;
            open_tag();
          end
          OP_BYTE: if (cur_phase != PH_IDLE) take_byte(in_data.data_byte);
          OP_END: if (cur_phase != PH_IDLE) finish_skip(1'b1, '0);
          default: ;
        endcase
      end
      pending_results <= expected_q.size();
    end
  end

  initial begin
    fail_count = 0;
    pending_results = 0;
    ok_results = 0;
    err_results = 0;
  end
endmodule

@@ test/tb_top.sv @@
// Testbench top for the group skipper: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps
module tb_top
  import wfgs_pkg::*;
();

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending_results;
  int        ok_results;
  int        err_results;
  int        cycle_count;
  int        sent_items;
  bit        calm_stretch;
  logic [7:0] byte_q [$];

  wire_format_group_skipper_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tb_skip_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_results(pending_results),
    .ok_results(ok_results), .err_results(err_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout guard.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("wire_format_group_skipper_core regression: fail");
        $finish;
      end
    end
  end

  // Random receiver stalls, quiet during the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm_stretch && ($urandom_range(99) < 9);
  end

  // Drive one item, with optional random gap before it, and wait for its transfer.
  task automatic send_item(input opcode_t op, input logic [7:0] b, input logic [28:0] sf);
    in_item_t it;
    while (!calm_stretch && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.opcode = op;
    it.data_byte = b;
    it.start_field = sf;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // Append one byte to the queue of bytes to send.
  task automatic queue_byte(input logic [7:0] b);
    byte_q.insert(byte_q.size(), b);
  endtask

  // Send the queued bytes.
  task automatic flush_bytes();
    while (byte_q.size() > 0) send_item(OP_BYTE, byte_q.pop_front(), 29'($urandom));
  endtask

  task automatic push_varint(input logic [63:0] v, input int min_len);
    int n;
    n = 0;
    while (v >= 64'h80 || n + 1 < min_len) begin
      queue_byte({1'b1, v[6:0]});
      v >>= 7;
      n++;
    end
    queue_byte({1'b0, v[6:0]});
  endtask

  task automatic push_tag(input logic [28:0] fld, input logic [2:0] wt);
    push_varint({32'b0, fld, wt}, 1);
  endtask

  // Queue a random well-formed field; groups recurse to a bounded depth.
  task automatic push_field(input int lvl);
    logic [28:0] fld;
    int kind;
    int len;
    fld = ($urandom_range(3) == 0) ? 29'($urandom) : 29'($urandom_range(1, 40));
    if (fld == 0) fld = 1;
    kind = $urandom_range(lvl < 3 ? 4 : 3);
    case (kind)
      0: begin
        push_tag(fld, WT_VARINT);
        push_varint({$urandom, $urandom}, $urandom_range(1, 10));
      end
      1: begin
        push_tag(fld, WT_FIX64);
        repeat (8) queue_byte(8'($urandom));
      end
      2: begin
        push_tag(fld, WT_FIX32);
        repeat (4) queue_byte(8'($urandom));
      end
      3: begin
        len = $urandom_range(0, 6);
        push_tag(fld, WT_LEN);
        push_varint(64'(len), $urandom_range(1, 5));
        repeat (len) queue_byte(8'($urandom));
      end
      default: begin
        push_tag(fld, WT_SGROUP);
        repeat ($urandom_range(0, 2)) push_field(lvl + 1);
        push_tag(fld, WT_EGROUP);
      end
    endcase
  endtask

  // One random skip: mostly well formed, sometimes corrupted, truncated or followed by stray bytes.
  task automatic random_skip();
    logic [28:0] top;
    int mode;
    top = ($urandom_range(1) == 0) ? 29'($urandom_range(1, 20)) : 29'($urandom);
    if (top == 0) top = 1;
    mode = $urandom_range(9);
    send_item(OP_START, 8'($urandom), top);
    repeat ($urandom_range(0, 3)) push_field(0);
    push_tag(top, WT_EGROUP);
    if (mode == 7) byte_q[$urandom_range(byte_q.size() - 1)] = 8'($urandom);
    if (mode == 8) begin
      byte_q.delete(byte_q.size() - 1);
      flush_bytes();
      send_item(OP_END, 8'($urandom), 29'($urandom));
    end else if (mode == 9) begin
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      flush_bytes();
    end else flush_bytes();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    calm_stretch = 1'b0;
    sent_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle bytes and ends, opcode 3, then an empty skip and a skip over a ten-byte varint.
    send_item(OP_BYTE, 8'hFF, '0);
    send_item(OP_END, 8'h00, '0);
    send_item(OP_NONE, 8'h55, 29'h1FFF_FFFF);
    send_item(OP_START, 8'h00, 29'h1FFF_FFFF);
    push_tag(29'h1FFF_FFFF, WT_EGROUP);
    flush_bytes();
    send_item(OP_START, 8'h00, 29'd1);
    push_tag(29'd2, WT_VARINT);
    push_varint(64'hFFFF_FFFF_FFFF_FFFF, 10);
    push_tag(29'd1, WT_EGROUP);
    flush_bytes();
    // Field number zero, types 6 and 7, stray end-group.
    send_item(OP_START, 8'h00, 29'd1);
    send_item(OP_BYTE, 8'h00, '0);
    send_item(OP_START, 8'h00, 29'd1);
    send_item(OP_BYTE, 8'h0E, '0);
    send_item(OP_START, 8'h00, 29'd1);
    send_item(OP_BYTE, 8'h0F, '0);
    send_item(OP_START, 8'h00, 29'd3);
    push_tag(29'd4, WT_EGROUP);
    flush_bytes();
    // Over-long tag and varint, size fifth byte too large.
    send_item(OP_START, 8'h00, 29'd1);
    repeat (5) send_item(OP_BYTE, 8'h80, '0);
    send_item(OP_START, 8'h00, 29'd1);
    push_tag(29'd1, WT_VARINT);
    repeat (10) queue_byte(8'hFF);
    flush_bytes();
    send_item(OP_START, 8'h00, 29'd1);
    push_tag(29'd1, WT_LEN);
    repeat (4) queue_byte(8'h80);
    queue_byte(8'h10);
    flush_bytes();
    // Start field zero, restart mid-skip, end of data.
    send_item(OP_START, 8'h00, 29'd0);
    send_item(OP_BYTE, 8'h08, '0);
    send_item(OP_START, 8'h00, 29'd5);
    send_item(OP_END, 8'h00, '0);
    // Nesting to the limit and one beyond.
    send_item(OP_START, 8'h00, 29'd7);
    repeat (MaxNestingDefault - 1) push_tag(29'd9, WT_SGROUP);
    repeat (MaxNestingDefault - 1) push_tag(29'd9, WT_EGROUP);
    push_tag(29'd7, WT_EGROUP);
    flush_bytes();
    send_item(OP_START, 8'h00, 29'd7);
    repeat (MaxNestingDefault) push_tag(29'd9, WT_SGROUP);
    flush_bytes();

    // Random skips with a calm stretch in the middle.
    while (sent_items < 680) begin
      calm_stretch = (sent_items > 420 && sent_items < 560);
      if ($urandom_range(19) == 0)
        send_item(opcode_t'($urandom_range(3)), 8'($urandom), 29'($urandom));
      else random_skip();
    end
    calm_stretch = 1'b0;
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d items; %0d skips completed, %0d failures reported.",
             sent_items, ok_results, err_results);
    if (fail_count == 0) $display("wire_format_group_skipper_core regression: pass");
    else $display("wire_format_group_skipper_core regression: fail");
    $finish;
  end
endmodule
